@@ hw/rtl/bba_pkg.sv @@
`timescale 1ns / 1ps

package bba_pkg;

  // width of the heap size register and of free block counts
  localparam int HW = 11;
  // width of the header byte register
  localparam int HDRW = 6;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_ZERO    = 2'd2,
    ST_BADFREE = 2'd3
  } res_e;

  // input word
  typedef struct packed {
    logic        op;
    logic [31:0] request_bytes;
    logic [9:0]  block_index;
  } in_word_t;

  // output word
  typedef struct packed {
    res_e        status;
    logic [9:0]  granted_index;
    logic [2:0]  granted_order;
    logic [10:0] free_blocks;
  } out_word_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_ORDER,
    S_WALK,
    S_WALK_EV,
    S_SPLIT,
    S_MERGE,
    S_MERGE_EV,
    S_EMIT
  } state_e;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_CALC,
    CMD_ORDER,
    CMD_WALK_RD,
    CMD_WALK_EV,
    CMD_SPLIT,
    CMD_MARK,
    CMD_FREE_OK,
    CMD_MERGE_RD,
    CMD_MERGE_EV,
    CMD_FREE_WR,
    CMD_FAIL,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    res_e code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_free;
    logic req_zero;
    logic req_big;
    logic walk_more;
    logic found;
    logic free_ok;
    logic split_more;
    logic merge_more;
    logic merge_hit;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ hw/rtl/bba_ram.sv @@
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/bba_datapath.sv @@
`timescale 1ns / 1ps

module bba_datapath #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int ORDERS      = 8,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bba_pkg::ctrl_cmd_t      cmd_i,
  output bba_pkg::dp_stat_t       stat_o,
  input  logic                    heap_wr_i,
  input  logic                    hdr_wr_i,
  input  logic [31:0]             cfg_data_i,
  output logic [bba_pkg::HW-1:0]  heap_o,
  output logic [bba_pkg::HDRW-1:0] hdr_o,
  input  bba_pkg::in_word_t       in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output bba_pkg::out_word_t      out_word_o
);

  localparam int AW    = $clog2(NUM_BLOCKS);
  localparam int MX1   = (AW > ORDERS) ? AW : ORDERS;
  localparam int PW    = ((MX1 > bba_pkg::HW) ? MX1 : bba_pkg::HW) + 1;
  localparam int BSH   = $clog2(BLOCK_BYTES);
  localparam int QW    = 33 - BSH;
  localparam int TOP   = 1 << (ORDERS - 1);
  localparam int HSAT  = (NUM_BLOCKS > 1024) ? 1024 : NUM_BLOCKS;
  localparam logic [3:0] OMAX = 4'(ORDERS - 1);

  localparam int HW = bba_pkg::HW;

  // configuration and counters
  logic [HW-1:0]           heap_q, free_q;
  logic [bba_pkg::HDRW-1:0] hdr_q;
  logic [AW-1:0]           clr_q;
  // request registers
  logic                    op_q;
  logic [31:0]             req_q;
  logic [PW-1:0]           idx_q;
  logic [QW-1:0]           qv_q;
  logic [3:0]              want_q;
  // tile walk
  logic [PW-1:0]           pos_q, best_q, cur_q;
  logic                    found_q, ok_q;
  logic [3:0]              border_q, k_q;
  // result
  bba_pkg::res_e           res_code_q;
  logic [PW-1:0]           res_idx_q;
  logic [3:0]              res_ord_q;
  logic                    out_valid_q;
  bba_pkg::out_word_t      out_q;

  // tag memory port
  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [4:0]              wdata, rdata;

  logic                    rd_busy;
  logic [3:0]              rd_ord;
  logic [PW-1:0]           pos_step, buddy, split_addr, heap_ext;
  logic [4:0]              clr_tag;
  logic [3:0]              want_c;
  logic [HW-1:0]           heap_sat;

  assign rd_busy    = rdata[4];
  assign rd_ord     = rdata[3:0];
  assign heap_ext   = PW'(heap_q);
  assign pos_step   = pos_q + (PW'(1) << rd_ord);
  assign buddy      = cur_q ^ (PW'(1) << k_q);
  assign split_addr = best_q + (PW'(1) << (border_q - 4'd1));
  assign heap_sat   = (32'(cfg_data_i[HW-1:0]) > 32'(NUM_BLOCKS)) ?
                      HW'(NUM_BLOCKS) : cfg_data_i[HW-1:0];

  // rebuild pattern: top-order heads while a whole top block fits
  always_comb begin
    clr_tag = 5'd0;
    if (((PW'(clr_q) & PW'(TOP - 1)) == '0) &&
        (PW'(clr_q) + PW'(TOP) <= heap_ext)) begin
      clr_tag = {1'b0, OMAX};
    end
  end

  // order from size quotient: bit length of the low order bits
  always_comb begin
    want_c = 4'd0;
    for (int j = 0; j < ORDERS; j++) begin
      if (qv_q[j]) begin
        want_c = 4'(j + 1);
      end
    end
  end

  // status to the controller
  always_comb begin
    stat_o.clear_last = (clr_q == AW'(NUM_BLOCKS - 1));
    stat_o.op_free    = op_q;
    stat_o.req_zero   = (req_q == '0);
    stat_o.req_big    = ((qv_q >> (ORDERS - 1)) != '0);
    stat_o.walk_more  = (pos_q < heap_ext) && (!op_q || (pos_q <= idx_q));
    stat_o.found      = found_q;
    stat_o.free_ok    = ok_q;
    stat_o.split_more = (border_q > want_q);
    stat_o.merge_more = (k_q < OMAX) && (buddy < heap_ext);
    stat_o.merge_hit  = !rd_busy && (rd_ord == k_q);
    stat_o.out_busy   = out_valid_q && out_stall_i;
  end

  // tag memory access per command
  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = clr_tag;
    raddr = pos_q[AW-1:0];
    unique case (cmd_i.cmd)
      bba_pkg::CMD_CLEAR: begin
        we = 1'b1;
      end
      bba_pkg::CMD_MERGE_RD: begin
        raddr = buddy[AW-1:0];
      end
      bba_pkg::CMD_SPLIT: begin
        we    = 1'b1;
        waddr = split_addr[AW-1:0];
        wdata = {1'b0, border_q - 4'd1};
      end
      bba_pkg::CMD_MARK: begin
        we    = 1'b1;
        waddr = best_q[AW-1:0];
        wdata = {1'b1, want_q};
      end
      bba_pkg::CMD_FREE_WR: begin
        we    = 1'b1;
        waddr = cur_q[AW-1:0];
        wdata = {1'b0, k_q};
      end
      default: begin
      end
    endcase
  end

  bba_ram #(
    .WIDTH(5),
    .DEPTH(NUM_BLOCKS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= HW'(HSAT);
      free_q      <= HW'(HSAT);
      hdr_q       <= bba_pkg::HDRW'(12);
      clr_q       <= '0;
      found_q     <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (cmd_i.cmd != bba_pkg::CMD_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.cmd)
        bba_pkg::CMD_CLEAR: begin
          if (!heap_wr_i) begin
            clr_q <= clr_q + AW'(1);
          end
        end
        bba_pkg::CMD_LOAD: begin
          op_q    <= in_word_i.op;
          req_q   <= in_word_i.request_bytes;
          idx_q   <= PW'(in_word_i.block_index);
          pos_q   <= '0;
          found_q <= 1'b0;
          ok_q    <= 1'b0;
        end
        bba_pkg::CMD_CALC: begin
          qv_q <= QW'((33'(req_q) + 33'(hdr_q)) >> BSH);
        end
        bba_pkg::CMD_ORDER: begin
          want_q <= want_c;
        end
        bba_pkg::CMD_WALK_EV: begin
          pos_q <= pos_step;
          if (!op_q && !rd_busy && (rd_ord >= want_q) &&
              (!found_q || (rd_ord < border_q))) begin
            found_q  <= 1'b1;
            best_q   <= pos_q;
            border_q <= rd_ord;
          end
          if (op_q && (pos_q == idx_q) && rd_busy) begin
            ok_q <= 1'b1;
            k_q  <= rd_ord;
          end
        end
        bba_pkg::CMD_SPLIT: begin
          border_q <= border_q - 4'd1;
        end
        bba_pkg::CMD_MARK: begin
          free_q     <= free_q - (HW'(1) << want_q);
          res_code_q <= bba_pkg::ST_OK;
          res_idx_q  <= best_q;
          res_ord_q  <= want_q;
        end
        bba_pkg::CMD_FREE_OK: begin
          free_q <= free_q + (HW'(1) << k_q);
          cur_q  <= idx_q;
        end
        bba_pkg::CMD_MERGE_EV: begin
          if (buddy < cur_q) begin
            cur_q <= buddy;
          end
          k_q <= k_q + 4'd1;
        end
        bba_pkg::CMD_FREE_WR: begin
          res_code_q <= bba_pkg::ST_OK;
          res_idx_q  <= cur_q;
          res_ord_q  <= k_q;
        end
        bba_pkg::CMD_FAIL: begin
          res_code_q <= cmd_i.code;
          res_idx_q  <= '0;
          res_ord_q  <= '0;
        end
        bba_pkg::CMD_EMIT: begin
          out_valid_q         <= 1'b1;
          out_q.status        <= res_code_q;
          out_q.granted_index <= res_idx_q[9:0];
          out_q.granted_order <= res_ord_q[2:0];
          out_q.free_blocks   <= free_q;
        end
        default: begin
        end
      endcase
      // configuration writes; the user must make them only while idle, the block itself does not enforce it
      if (heap_wr_i) begin
        heap_q <= heap_sat;
        free_q <= heap_sat;
        clr_q  <= '0;
      end
      if (hdr_wr_i) begin
        hdr_q <= cfg_data_i[bba_pkg::HDRW-1:0];
      end
    end
  end

  assign heap_o      = heap_q;
  assign hdr_o       = hdr_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ hw/rtl/bba_ctrl.sv @@
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               heap_wr_i,
  input  bba_pkg::dp_stat_t  stat_i,
  output bba_pkg::ctrl_cmd_t cmd_o
);

  bba_pkg::state_e state_q, state_d;

  // state register; reset starts with the rebuild pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o.cmd  = bba_pkg::CMD_NONE;
    cmd_o.code = bba_pkg::ST_OK;
    in_stall_o = 1'b1;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        cmd_o.cmd = bba_pkg::CMD_CLEAR;
        if (stat_i.clear_last) begin
          state_d = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cmd = bba_pkg::CMD_LOAD;
          state_d   = bba_pkg::S_CALC;
        end
      end
      bba_pkg::S_CALC: begin
        // free requests go straight to the walk
        if (stat_i.op_free) begin
          state_d = bba_pkg::S_WALK;
        end else begin
          cmd_o.cmd = bba_pkg::CMD_CALC;
          state_d   = bba_pkg::S_ORDER;
        end
      end
      bba_pkg::S_ORDER: begin
        if (stat_i.req_zero) begin
          cmd_o.cmd  = bba_pkg::CMD_FAIL;
          cmd_o.code = bba_pkg::ST_ZERO;
          state_d    = bba_pkg::S_EMIT;
        end else if (stat_i.req_big) begin
          cmd_o.cmd  = bba_pkg::CMD_FAIL;
          cmd_o.code = bba_pkg::ST_NOMEM;
          state_d    = bba_pkg::S_EMIT;
        end else begin
          cmd_o.cmd = bba_pkg::CMD_ORDER;
          state_d   = bba_pkg::S_WALK;
        end
      end
      bba_pkg::S_WALK: begin
        if (stat_i.walk_more) begin
          cmd_o.cmd = bba_pkg::CMD_WALK_RD;
          state_d   = bba_pkg::S_WALK_EV;
        end else if (stat_i.op_free) begin
          if (stat_i.free_ok) begin
            cmd_o.cmd = bba_pkg::CMD_FREE_OK;
            state_d   = bba_pkg::S_MERGE;
          end else begin
            cmd_o.cmd  = bba_pkg::CMD_FAIL;
            cmd_o.code = bba_pkg::ST_BADFREE;
            state_d    = bba_pkg::S_EMIT;
          end
        end else if (stat_i.found) begin
          state_d = bba_pkg::S_SPLIT;
        end else begin
          cmd_o.cmd  = bba_pkg::CMD_FAIL;
          cmd_o.code = bba_pkg::ST_NOMEM;
          state_d    = bba_pkg::S_EMIT;
        end
      end
      bba_pkg::S_WALK_EV: begin
        cmd_o.cmd = bba_pkg::CMD_WALK_EV;
        state_d   = bba_pkg::S_WALK;
      end
      bba_pkg::S_SPLIT: begin
        if (stat_i.split_more) begin
          cmd_o.cmd = bba_pkg::CMD_SPLIT;
        end else begin
          cmd_o.cmd = bba_pkg::CMD_MARK;
          state_d   = bba_pkg::S_EMIT;
        end
      end
      bba_pkg::S_MERGE: begin
        if (stat_i.merge_more) begin
          cmd_o.cmd = bba_pkg::CMD_MERGE_RD;
          state_d   = bba_pkg::S_MERGE_EV;
        end else begin
          cmd_o.cmd = bba_pkg::CMD_FREE_WR;
          state_d   = bba_pkg::S_EMIT;
        end
      end
      bba_pkg::S_MERGE_EV: begin
        if (stat_i.merge_hit) begin
          cmd_o.cmd = bba_pkg::CMD_MERGE_EV;
          state_d   = bba_pkg::S_MERGE;
        end else begin
          cmd_o.cmd = bba_pkg::CMD_FREE_WR;
          state_d   = bba_pkg::S_EMIT;
        end
      end
      bba_pkg::S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.cmd = bba_pkg::CMD_EMIT;
          state_d   = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bba_pkg::S_CLEAR;
      end
    endcase
    // a heap size write restarts the rebuild pass
    if (heap_wr_i) begin
      state_d = bba_pkg::S_CLEAR;
    end
  end

endmodule

@@ hw/rtl/buddy_block_allocator.sv @@
`timescale 1ns / 1ps

// Buddy allocator over a heap of minimum blocks held in a simple dual-port tag
// RAM (one read and one write a cycle, registered read). One word is worked at
// a time. After reset and after every heap_blocks write a rebuild pass sweeps
// all NUM_BLOCKS tag entries, one a cycle, with in_stall_o high. An allocate
// walks the block heads of the tile and picks the smallest free block that
// fits, then splits it down; a free walks to its block, then merges it with
// free buddies until a buddy check fails, the buddy lies beyond the heap or
// the top order is reached. Each walk or merge step reads the RAM and then
// evaluates the registered read data. The result sits in an output register,
// so a word can be taken while the previous result still waits.

module buddy_block_allocator #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int ORDERS      = 8,
  parameter int BLOCK_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bba_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bba_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  bba_pkg::ctrl_cmd_t cmd;
  bba_pkg::dp_stat_t  stat;
  logic               cfg_wr, heap_wr, hdr_wr;
  logic [bba_pkg::HW-1:0]   heap;
  logic [bba_pkg::HDRW-1:0] hdr;

  // register decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign heap_wr = cfg_wr && !paddr[2];
  assign hdr_wr  = cfg_wr && paddr[2];
  assign prdata  = paddr[2] ? 32'(hdr) : 32'(heap);

  bba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .heap_wr_i (heap_wr),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .ORDERS     (ORDERS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .heap_wr_i  (heap_wr),
    .hdr_wr_i   (hdr_wr),
    .cfg_data_i (pwdata),
    .heap_o     (heap),
    .hdr_o      (hdr),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // one word in flight: busy right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted twice in a row");

  // a heap size write starts the rebuild pass
  a_rebuild_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_wr |=> in_stall_o)
    else $error("input open during rebuild");

  // failed requests carry no grant
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status != bba_pkg::ST_OK)) |->
    ((out_word_o.granted_index == '0) && (out_word_o.granted_order == '0)))
    else $error("grant fields set on a failed request");

endmodule

@@ dv/buddy_block_allocator_tb.sv @@
`timescale 1ns / 1ps

module buddy_block_allocator_tb;

  localparam int NBLK = 1024;
  localparam int NORD = 8;
  localparam int BBYTES = 64;
  localparam int TOP = 1 << (NORD - 1);
  localparam logic [2:0] ADDR_HEAP = 3'd0;
  localparam logic [2:0] ADDR_HDR = 3'd4;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;
  localparam int IDLE_LIMIT = 20000;

  // allocator shadow: tag array, free count and config
  class alloc_scoreboard;
    logic [4:0] tag[NBLK];
    int unsigned free_cnt;
    int unsigned heap;
    int unsigned hdr;
    bba_pkg::out_word_t pending[$];
    int errors;
    int live[$];
    int n_ok, n_nomem, n_zero, n_bad, n_merge;

    function void rebuild();
      for (int i = 0; i < NBLK; i++) tag[i] = '0;
      for (int i = 0; i < heap / TOP; i++) tag[i * TOP] = 5'(NORD - 1);
      free_cnt = heap;
      live.delete();
    endfunction

    function void set_reg(logic [2:0] a, logic [31:0] v);
      int unsigned w;
      if (a == ADDR_HEAP) begin
        w = v & 32'h7ff;
        heap = (w > NBLK) ? NBLK : w;
        rebuild();
      end else begin
        hdr = v & 32'h3f;
      end
    endfunction

    function void note_word(bba_pkg::in_word_t w);
      bba_pkg::out_word_t r;
      longint unsigned q;
      int unsigned want, pos, o, best, bord, k, cur, b, idx;
      bit found, ok;
      r = '0;
      if (w.op == OP_ALLOC) begin
        if (w.request_bytes == 0) begin
          r.status = bba_pkg::ST_ZERO;
          n_zero++;
        end else begin
          q = (longint'(w.request_bytes) + hdr) / BBYTES;
          want = 0;
          while (q != 0) begin
            want++;
            q >>= 1;
          end
          found = 0;
          best = 0;
          bord = 0;
          if (want < NORD) begin
            pos = 0;
            while (pos < heap) begin
              o = tag[pos][3:0];
              if (!tag[pos][4] && o >= want && (!found || o < bord)) begin
                found = 1;
                best = pos;
                bord = o;
              end
              pos += 1 << o;
            end
          end
          if (!found) begin
            r.status = bba_pkg::ST_NOMEM;
            n_nomem++;
          end else begin
            for (int i = int'(bord) - 1; i >= int'(want); i--)
              tag[(best + (1 << i)) % NBLK] = 5'(i);
            tag[best] = 5'(want) | 5'h10;
            free_cnt -= 1 << want;
            r.status = bba_pkg::ST_OK;
            r.granted_index = 10'(best);
            r.granted_order = 3'(want);
            live.push_back(best);
            n_ok++;
          end
        end
      end else begin
        idx = w.block_index;
        ok = 0;
        pos = 0;
        while (pos < heap && pos <= idx) begin
          if (pos == idx && tag[pos][4]) ok = 1;
          pos += 1 << tag[pos][3:0];
        end
        if (!ok) begin
          r.status = bba_pkg::ST_BADFREE;
          n_bad++;
        end else begin
          k = tag[idx][3:0];
          free_cnt += 1 << k;
          cur = idx;
          while (k < NORD - 1) begin
            b = cur ^ (1 << k);
            if (b >= heap) break;
            if (tag[b][4] || tag[b][3:0] != k) break;
            if (b < cur) cur = b;
            k++;
            n_merge++;
          end
          tag[cur] = 5'(k);
          foreach (live[j]) if (live[j] == idx) begin
            live.delete(j);
            break;
          end
          r.status = bba_pkg::ST_OK;
          r.granted_index = 10'(cur);
          r.granted_order = 3'(k);
        end
      end
      r.free_blocks = 11'(free_cnt);
      pending.push_back(r);
    endfunction

    function void check_word(bba_pkg::out_word_t a);
      bba_pkg::out_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status);
        errors++;
      end
      if (a.granted_index !== e.granted_index) begin
        $error("granted_index exp %0d got %0d", e.granted_index, a.granted_index);
        errors++;
      end
      if (a.granted_order !== e.granted_order) begin
        $error("granted_order exp %0d got %0d", e.granted_order, a.granted_order);
        errors++;
      end
      if (a.free_blocks !== e.free_blocks) begin
        $error("free_blocks exp %0d got %0d", e.free_blocks, a.free_blocks);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  bba_pkg::in_word_t in_word = '0;
  bba_pkg::out_word_t out_word;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  alloc_scoreboard sb;
  int idle_cnt = 0;
  int out_idle_pct = 12;
  int in_idle_pct = 12;
  int n_words = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  buddy_block_allocator uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // result side: random stall, check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(logic op, logic [31:0] req, logic [9:0] idx);
    do @(negedge clk); while ($urandom_range(99) < in_idle_pct);
    in_word <= '{op: op, request_bytes: req, block_index: idx};
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_word(in_word);
    n_words++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic do_alloc(logic [31:0] req);
    send_word(OP_ALLOC, req, 10'($urandom));
  endtask

  task automatic do_free(logic [9:0] idx);
    send_word(OP_FREE, $urandom, idx);
  endtask

  // wait for all results, then give the block time to settle
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [31:0] v);
    drain();
    psel <= 1;
    pwrite <= 1;
    paddr <= a;
    pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(a, v);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // random request size, mostly small orders
  function automatic logic [31:0] rand_req();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'($urandom_range(0, 3));
      2, 3: return 32'($urandom_range(1, 128));
      default: return 32'($urandom_range(1, 64 << $urandom_range(0, 6)));
    endcase
  endfunction

  task automatic rand_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (i == n / 2 + 60) begin
        in_idle_pct = 12;
        out_idle_pct = 12;
      end
      case ($urandom_range(9))
        0, 1, 2, 3, 4: do_alloc(rand_req());
        5, 6, 7: begin
          if (sb.live.size() != 0) do_free(10'(sb.live[$urandom_range(sb.live.size() - 1)]));
          else do_free(10'($urandom));
        end
        8: do_free(10'($urandom));
        default: do_alloc(32'($urandom_range(0, 200)));
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.heap = NBLK;
    sb.hdr = 12;
    sb.rebuild();
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes and special cases
    do_alloc(32'd0);
    do_alloc(32'hffff_ffff);
    do_alloc(32'd1);
    do_alloc(32'd51);
    do_alloc(32'd52);
    do_alloc(32'd8180);
    do_alloc(32'd8000);
    do_free(10'd0);
    do_free(10'd0);
    do_free(10'd3);
    do_free(10'h3ff);
    do_free(10'd1);
    do_free(10'd2);
    write_reg(ADDR_HDR, 32'd0);
    do_alloc(32'd63);
    do_alloc(32'd64);
    write_reg(ADDR_HDR, 32'd63);
    do_alloc(32'd1);
    write_reg(ADDR_HEAP, 32'h7ff);
    do_alloc(32'd4);
    write_reg(ADDR_HEAP, 32'd0);
    do_alloc(32'd4);
    do_free(10'd0);
    write_reg(ADDR_HEAP, 32'd131);
    do_alloc(32'd4);
    do_alloc(32'd4);
    do_alloc(32'd4);
    do_alloc(32'd4);
    do_free(10'd128);
    do_free(10'd129);

    // random phases over a few heap settings
    write_reg(ADDR_HDR, 32'd12);
    write_reg(ADDR_HEAP, 32'd1024);
    rand_phase(300);
    write_reg(ADDR_HEAP, 32'd200);
    write_reg(ADDR_HDR, 32'd0);
    rand_phase(200);
    write_reg(ADDR_HEAP, 32'd3);
    write_reg(ADDR_HDR, 32'd63);
    rand_phase(80);
    write_reg(ADDR_HEAP, 32'd1023);
    write_reg(ADDR_HDR, 32'd30);
    rand_phase(270);

    drain();
    $display("%0d words sent: %0d grants, %0d no-memory, %0d zero-size, %0d bad frees",
             n_words, sb.n_ok, sb.n_nomem, sb.n_zero, sb.n_bad);
    $display("%0d buddy merges seen over several heap and header settings", sb.n_merge);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
